// ===== hw/rtl/ray_box_angular_hit_test_top_defines.svh =====
// assertion macros for the ray box hit test
`ifndef RAY_BOX_ANGULAR_HIT_TEST_TOP_DEFINES_SVH
`define RAY_BOX_ANGULAR_HIT_TEST_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define RBH_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define RBH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define RBH_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define RBH_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/rbh_pkg.sv =====
// ----------------------------------------------------------------------------
// rbh_pkg
// shared constants and cordic angle table
// ----------------------------------------------------------------------------
package rbh_pkg;
  localparam int COORD_BITS_DEF    = 10;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int FRAC_SHIFT        = 16;
  localparam int OUT_SHIFT         = 9;
  localparam int ZW                = 26;
  localparam int HW                = 18;
  localparam logic signed [HW-1:0] DEG90  = 18'sd11520;
  localparam logic signed [HW-1:0] DEG180 = 18'sd23040;
  localparam logic signed [HW-1:0] DEG270 = 18'sd34560;

  function automatic logic signed [ZW-1:0] atan_tab(input int i);
    logic signed [ZW-1:0] r;
    begin
      case (i)
        0: r = 26'sd2949120;  1: r = 26'sd1740967;  2: r = 26'sd919879;
        3: r = 26'sd466945;   4: r = 26'sd234379;   5: r = 26'sd117304;
        6: r = 26'sd58666;    7: r = 26'sd29335;    8: r = 26'sd14668;
        9: r = 26'sd7334;     10: r = 26'sd3667;    11: r = 26'sd1833;
        12: r = 26'sd917;     13: r = 26'sd458;     14: r = 26'sd229;
        15: r = 26'sd115;     16: r = 26'sd57;      17: r = 26'sd29;
        18: r = 26'sd14;      19: r = 26'sd7;       20: r = 26'sd4;
        21: r = 26'sd2;       22: r = 26'sd1;       default: r = '0;
      endcase
      return r;
    end
  endfunction
endpackage

// ===== hw/rtl/rbh_cell.sv =====
// ----------------------------------------------------------------------------
// rbh_cell
// one cordic vectoring micro-rotation for three lanes plus sideband
// ----------------------------------------------------------------------------
module rbh_cell import rbh_pkg::*; #(
  parameter int VW    = 34,
  parameter int STAGE = 0,
  parameter int SBW   = 2
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [VW-1:0]  x_in  [3],
  input  logic signed [VW-1:0]  y_in  [3],
  input  logic signed [ZW-1:0]  z_in  [3],
  input  logic [SBW-1:0]        sb_in,
  output logic signed [VW-1:0]  x_out [3],
  output logic signed [VW-1:0]  y_out [3],
  output logic signed [ZW-1:0]  z_out [3],
  output logic [SBW-1:0]        sb_out
);
  localparam logic signed [ZW-1:0] ANG = atan_tab(STAGE);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        if (!y_in[k][VW-1]) begin
          x_out[k] <= x_in[k] + (y_in[k] >>> STAGE);
          y_out[k] <= y_in[k] - (x_in[k] >>> STAGE);
          z_out[k] <= z_in[k] + ANG;
        end else begin
          x_out[k] <= x_in[k] - (y_in[k] >>> STAGE);
          y_out[k] <= y_in[k] + (x_in[k] >>> STAGE);
          z_out[k] <= z_in[k] - ANG;
        end
      end
      sb_out <= sb_in;
    end
  end
endmodule

// ===== hw/rtl/ray_box_angular_hit_test_top.sv =====
// result path: input register, cordic cell chain, then the registered hit bit
// throughput: one beat per cycle while the result is not held, set by the cordic cell chain
// the whole chain advances together; it stalls only when the result is held
// reset clears the valid flags only; no clearing pass
// ----------------------------------------------------------------------------
// ray_box_angular_hit_test_top
// region select, three-lane cordic heading chain and angular span compare
// ----------------------------------------------------------------------------
`include "ray_box_angular_hit_test_top_defines.svh"
module ray_box_angular_hit_test_top import rbh_pkg::*; #(
  parameter int COORD_BITS    = COORD_BITS_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COORD_BITS-1:0] start_x,
  input  logic [COORD_BITS-1:0] start_y,
  input  logic [COORD_BITS-1:0] end_x,
  input  logic [COORD_BITS-1:0] end_y,
  input  logic [COORD_BITS-1:0] box_x,
  input  logic [COORD_BITS-1:0] box_y,
  input  logic [COORD_BITS-1:0] box_width,
  input  logic [COORD_BITS-1:0] box_height,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  hit
);
  localparam int CW    = COORD_BITS + 2;
  localparam int VW    = CW + FRAC_SHIFT + 3;
  localparam int NS    = CORDIC_STAGES;
  localparam int PIPE  = NS + 2;

  logic en;
  logic [PIPE-1:0] vld;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // stage 0: region select, deltas, prescaled vectors
  logic [CW-1:0] x1, y1, x2, y2, sx, sy;
  logic above, below, lft, rgt;
  logic [CW-1:0] tx [3];
  logic [CW-1:0] ty [3];
  logic signed [VW-1:0] x0 [3];
  logic signed [VW-1:0] y0 [3];
  logic [2:0] rt0;

  always_comb begin
    sx = CW'(start_x);
    sy = CW'(start_y);
    x1 = CW'(box_x);
    y1 = CW'(box_y);
    x2 = CW'(box_x) + CW'(box_width);
    y2 = CW'(box_y) + CW'(box_height);
    above = sy < y1;
    below = sy > y2;
    lft   = sx < x1;
    rgt   = sx > x2;
    tx[0] = CW'(end_x);
    ty[0] = CW'(end_y);
    if (!lft && !rgt) begin
      tx[1] = x1; tx[2] = x2;
      ty[1] = above ? y1 : y2; ty[2] = above ? y1 : y2;
    end else if (!above && !below) begin
      tx[1] = lft ? x1 : x2; tx[2] = lft ? x1 : x2;
      ty[1] = y1; ty[2] = y2;
    end else if (lft == above) begin
      tx[1] = x2; ty[1] = y1; tx[2] = x1; ty[2] = y2;
    end else begin
      tx[1] = x1; ty[1] = y1; tx[2] = x2; ty[2] = y2;
    end
    for (int k = 0; k < 3; k++) begin
      logic signed [CW:0] dx, dy;
      dx = $signed({1'b0, tx[k]}) - $signed({1'b0, sx});
      dy = $signed({1'b0, ty[k]}) - $signed({1'b0, sy});
      if (dx == '0) dx = (CW+1)'(1);
      rt0[k] = !dx[CW];
      if (dx[CW]) begin
        dx = -dx;
        dy = -dy;
      end
      x0[k] = VW'(dx) <<< FRAC_SHIFT;
      y0[k] = VW'(dy) <<< FRAC_SHIFT;
    end
  end

  logic signed [VW-1:0] xs [NS+1][3];
  logic signed [VW-1:0] ys [NS+1][3];
  logic signed [ZW-1:0] zs [NS+1][3];
  logic [2:0]           sbs [NS+1];

  logic signed [VW-1:0] x_q0 [3];
  logic signed [VW-1:0] y_q0 [3];
  logic [2:0]           rt_q0;

  always_ff @(posedge clk) begin
    if (en) begin
      x_q0  <= x0;
      y_q0  <= y0;
      rt_q0 <= rt0;
    end
  end

  assign xs[0]  = x_q0;
  assign ys[0]  = y_q0;
  assign zs[0]  = '{default: '0};
  assign sbs[0] = rt_q0;

  for (genvar g = 0; g < NS; g++) begin : g_cell
    rbh_cell #(.VW(VW), .STAGE(g), .SBW(3)) u_cell (
      .clk(clk), .en(en),
      .x_in(xs[g]), .y_in(ys[g]), .z_in(zs[g]), .sb_in(sbs[g]),
      .x_out(xs[g+1]), .y_out(ys[g+1]), .z_out(zs[g+1]), .sb_out(sbs[g+1])
    );
  end

  // headings and compare
  logic signed [HW-1:0] hd [3];
  logic signed [HW-1:0] dif;
  logic hit_next;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic signed [ZW-1:0] zr;
      zr = zs[NS][k] + ZW'(1 << (OUT_SHIFT - 1));
      hd[k] = HW'(zr >>> OUT_SHIFT) + (sbs[NS][k] ? DEG90 : DEG270);
    end
    dif = hd[1] - hd[2];
    if (dif[HW-1]) dif = -dif;
    if (dif < DEG180) begin
      if (hd[1] < hd[2]) hit_next = (hd[0] > hd[1]) && (hd[0] < hd[2]);
      else               hit_next = (hd[0] < hd[1]) && (hd[0] > hd[2]);
    end else if (hd[0] > DEG90) begin
      hit_next = (hd[0] > hd[1]) && (hd[0] > hd[2]);
    end else begin
      hit_next = (hd[0] < hd[1]) && (hd[0] < hd[2]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) hit <= hit_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE-2:0], in_valid};
    end
  end
  assign out_valid = vld[PIPE-1];

  `RBH_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(hit), "result lost while stalled")
  `RBH_ASSERT_IMPL(a_ready, clk, rst, !out_valid, in_ready, "not ready with empty output")
  `RBH_ASSERT_NEXT(a_adv, clk, rst, in_valid && in_ready, vld[0], "accepted beat not tracked")
endmodule

// ===== tb/tb_ray_box_angular_hit_test_top.sv =====
// ----------------------------------------------------------------------------
// ray box angular hit test testbench
// drives ray and box queries through the handshake, predicts the hit bit with
// a local fixed point cordic heading model and checks each result in order
// ----------------------------------------------------------------------------
module tb_ray_box_angular_hit_test_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rbh_pkg::*;

  localparam int CB = COORD_BITS_DEF;
  localparam int NST = CORDIC_STAGES_DEF;
  localparam int LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [CB-1:0] start_x = '0, start_y = '0, end_x = '0, end_y = '0;
  logic [CB-1:0] box_x = '0, box_y = '0, box_width = '0, box_height = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic hit;

  bit hit_expected_q[$];
  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off = 0;

  ray_box_angular_hit_test_top DUT (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
    .box_x(box_x), .box_y(box_y), .box_width(box_width), .box_height(box_height),
    .out_valid(out_valid), .out_ready(out_ready), .hit(hit)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic longint fshr(longint v, int s);
    return v >>> s;
  endfunction

  // heading from s toward t in 1/128 degree units
  function automatic longint heading_of(longint sx, longint sy, longint tx, longint ty);
    longint dx, dy, x, y, z, xs, ys;
    bit rgt;
    dx = tx - sx;
    dy = ty - sy;
    z = 0;
    if (dx == 0) dx = 1;
    rgt = dx > 0;
    if (!rgt) begin
      dx = -dx;
      dy = -dy;
    end
    x = dx <<< FRAC_SHIFT;
    y = dy <<< FRAC_SHIFT;
    for (int i = 0; i < NST && i < 24; i++) begin
      xs = fshr(x, i);
      ys = fshr(y, i);
      if (y >= 0) begin
        x = x + ys; y = y - xs; z = z + longint'(atan_tab(i));
      end else begin
        x = x - ys; y = y + xs; z = z - longint'(atan_tab(i));
      end
    end
    return fshr(z + (1 <<< (OUT_SHIFT - 1)), OUT_SHIFT) + (rgt ? 11520 : 34560);
  endfunction

  function automatic bit predict_hit(longint sx, longint sy, longint ex, longint ey,
                                     longint x1, longint y1, longint w, longint h);
    longint x2, y2, ax, ay, bx, by, a, b, l, d;
    bit above, below, lft, rgt;
    x2 = x1 + w;
    y2 = y1 + h;
    above = sy < y1; below = sy > y2; lft = sx < x1; rgt = sx > x2;
    if (!lft && !rgt) begin
      if (above) begin ax = x1; ay = y1; bx = x2; by = y1; end
      else begin ax = x1; ay = y2; bx = x2; by = y2; end
    end else if (!above && !below) begin
      if (lft) begin ax = x1; ay = y1; bx = x1; by = y2; end
      else begin ax = x2; ay = y1; bx = x2; by = y2; end
    end else if (lft) begin
      if (above) begin ax = x2; ay = y1; bx = x1; by = y2; end
      else begin ax = x1; ay = y1; bx = x2; by = y2; end
    end else begin
      if (above) begin ax = x1; ay = y1; bx = x2; by = y2; end
      else begin ax = x2; ay = y1; bx = x1; by = y2; end
    end
    l = heading_of(sx, sy, ex, ey);
    a = heading_of(sx, sy, ax, ay);
    b = heading_of(sx, sy, bx, by);
    d = (a > b) ? a - b : b - a;
    if (d < 23040) begin
      if (a < b) return (l > a) && (l < b);
      return (l < a) && (l > b);
    end
    if (l > 11520) return (l > a) && (l > b);
    return (l < a) && (l < b);
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    errors++;
  endtask

  task automatic send_query(input logic [CB-1:0] sx, sy, ex, ey, bx, by, bw, bh);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    start_x <= sx; start_y <= sy; end_x <= ex; end_y <= ey;
    box_x <= bx; box_y <= by; box_width <= bw; box_height <= bh;
    in_valid <= 1'b1;
    hit_expected_q.push_back(predict_hit(sx, sy, ex, ey, bx, by, bw, bh));
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // receiver side
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (hit_expected_q.size() == 0) report_mismatch("result beat with nothing expected");
        else begin
          bit e;
          e = hit_expected_q.pop_front();
          if (hit !== e) report_mismatch($sformatf("hit %b expected %b", hit, e));
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_ready <= 1'b0;
      end else out_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [CB-1:0] rc();
    return CB'($urandom);
  endfunction

  task automatic random_query();
    logic [CB-1:0] bx, by, bw, bh, sx, sy, ex, ey;
    int big;
    big = $urandom_range(3) == 0;
    bw = big ? rc() : CB'($urandom_range(60));
    bh = big ? rc() : CB'($urandom_range(60));
    bx = rc(); by = rc();
    sx = rc(); sy = rc();
    case ($urandom_range(3))
      0: begin // aim at a point inside the box
        ex = CB'(bx + $urandom_range(bw)); ey = CB'(by + $urandom_range(bh));
      end
      1: begin ex = sx; ey = rc(); end
      default: begin ex = rc(); ey = rc(); end
    endcase
    send_query(sx, sy, ex, ey, bx, by, bw, bh);
  endtask

  task automatic test_directed();
    logic [CB-1:0] mx;
    mx = '1;
    // one start per region around a box at 400..500
    for (int r = 0; r < 9; r++)
      send_query(CB'(200 + (r % 3) * 250), CB'(200 + (r / 3) * 250), 450, 450,
                 400, 400, 100, 100);
    send_query(450, 450, 450, 450, 400, 400, 100, 100); // start on end, inside
    send_query(100, 100, 100, 900, 400, 400, 100, 100); // vertical ray
    send_query(100, 900, 100, 0, 400, 400, 0, 0);       // empty box
    send_query(0, 0, mx, mx, mx, mx, mx, mx);
    send_query(mx, mx, 0, 0, 0, 0, 0, 0);
    send_query(mx, 0, 0, mx, 0, mx, mx, 0);
    send_query(0, mx, mx, 0, mx, 0, 0, mx);
    send_query(500, 100, 500, 300, 400, 400, 100, 100);
    send_query(500, 900, 300, 100, 400, 400, 100, 100);
  endtask

  task automatic test_random(input int n, input int sidle, input int rstall);
    send_idle_pct = sidle;
    recv_stall_pct = rstall;
    repeat (n) random_query();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    hold_off <= 300;
    repeat (80) random_query();
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (hit_expected_q.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (NST + 20) @(posedge clk);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(300, 0, 0);
    test_random(250, 80, 0);
    test_random(250, 0, 80);
    test_random(250, 26, 26);
    test_backpressure();
    test_random(100, 0, 0);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain();
    if (errors == 0 && hit_expected_q.size() == 0) $display("simulation ok");
    else begin
      if (hit_expected_q.size() != 0) report_mismatch("expected results left over");
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/rbh_pkg.sv
hw/rtl/rbh_cell.sv
hw/rtl/ray_box_angular_hit_test_top.sv
tb/tb_ray_box_angular_hit_test_top.sv
